// ===== sv/pcrt_pkg.sv =====
// Shared types and codes for the palette color remap table.
// Holds the request record that travels down the cell chain and the status codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pcrt_pkg;

  localparam int PAL_W   = 2;
  localparam int COLOR_W = 32;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_MAP  = 1'b1;

  typedef enum logic [2:0] {
    ST_MAPPED    = 3'd0,
    ST_PASSED    = 3'd1,
    ST_STORED    = 3'd2,
    ST_DUPLICATE = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  // One request in flight. On a map hit the key field is replaced by the
  // replacement color, so the result color is read from it at the end.
  typedef struct packed {
    logic               vld;
    logic               mode;
    logic [PAL_W-1:0]   palette;
    logic [COLOR_W-1:0] key;
    logic [COLOR_W-1:0] val;
    logic               done;
    status_t            status;
  } item_t;

endpackage

`default_nettype wire

// ===== sv/pcrt_cell.sv =====
// One table entry of the remap chain: a key, its replacement and a valid bit.
// Compares or stores the passing request and hands it to the next cell.
// Depends on pcrt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcrt_cell
  import pcrt_pkg::*;
#(
  parameter int CELL_PAL = 0
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  en,
  input  wire item_t item_in,
  output item_t      item_out
);

  logic               entry_vld;
  logic [COLOR_W-1:0] entry_key;
  logic [COLOR_W-1:0] entry_val;

  item_t item_next;
  logic  sel;
  logic  key_eq;
  logic  store;

  assign sel    = item_in.vld && !item_in.done && (int'(item_in.palette) == CELL_PAL);
  assign key_eq = entry_vld && (entry_key == item_in.key);

  // Entries fill in order, so the first empty cell of a palette is its
  // next free slot and every stored key lies in front of it.
  always_comb begin
    item_next = item_in;
    store     = 1'b0;
    if (sel) begin
      if (key_eq) begin
        item_next.done = 1'b1;
        if (item_in.mode == MODE_MAP) begin
          item_next.key    = entry_val;
          item_next.status = ST_MAPPED;
        end else begin
          item_next.status = ST_DUPLICATE;
        end
      end else if (!entry_vld && item_in.mode == MODE_LOAD) begin
        store            = 1'b1;
        item_next.done   = 1'b1;
        item_next.status = ST_STORED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_vld    <= 1'b0;
      item_out.vld <= 1'b0;
    end else if (en) begin
      item_out <= item_next;
      if (store) begin
        entry_vld <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && store) begin
      entry_key <= item_in.key;
      entry_val <= item_in.val;
    end
  end

endmodule

`default_nettype wire

// ===== sv/palette_color_remap_table_top.sv =====
// Top level of the palette color remap table: stream ports and the cell chain.
// Instantiates pcrt_cell; depends on pcrt_pkg.
`timescale 1ns / 1ps
`default_nettype none

// The block keeps PALETTE_COUNT palettes of ENTRIES_PER_PALETTE key/color
// pairs each, stored in one row of PALETTE_COUNT*ENTRIES_PER_PALETTE cells,
// palette after palette. Every request walks the whole row, one cell per
// cycle while the row advances, so the block takes one request per cycle
// unless a result waits at the output; each cell registers the request
// as it passes. A load request stores its pair in the first empty cell of
// its palette unless a cell in front of it already holds the key
// (duplicate) and reports full when it finds neither. A map request takes
// the replacement color from the matching cell and otherwise passes the
// pixel through. Results leave in request order. The whole row advances
// together: when a result waits at the output and is not taken, the row
// holds and no new request is taken. Reset clears all valid bits at once;
// no clearing pass is needed.

module palette_color_remap_table_top
  import pcrt_pkg::*;
#(
  parameter int PALETTE_COUNT       = 4,
  parameter int ENTRIES_PER_PALETTE = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // key_color[31:0], new_color[63:32]
  input  wire logic [2:0]  s_axis_tuser,   // mode[0], palette[2:1]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // color[31:0]
  output logic [2:0]       m_axis_tuser    // status[2:0]
);

  localparam int TOTAL = PALETTE_COUNT * ENTRIES_PER_PALETTE;

  item_t chain [0:TOTAL];
  logic  en;

  // Advance the row whenever the output register is empty or being taken.
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // Form the request entering the first cell; the default result is full
  // for a load and pass-through for a map, which also covers palette
  // indexes that no cell owns.
  always_comb begin
    chain[0].vld     = s_axis_tvalid;
    chain[0].mode    = s_axis_tuser[0];
    chain[0].palette = s_axis_tuser[2:1];
    chain[0].key     = s_axis_tdata[31:0];
    chain[0].val     = s_axis_tdata[63:32];
    chain[0].done    = 1'b0;
    chain[0].status  = (s_axis_tuser[0] == MODE_MAP) ? ST_PASSED : ST_FULL;
  end

  for (genvar i = 0; i < TOTAL; i++) begin : g_cell
    localparam int CELL_PAL = i / ENTRIES_PER_PALETTE;
    pcrt_cell #(
      .CELL_PAL(CELL_PAL)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .item_in (chain[i]),
      .item_out(chain[i+1])
    );
  end

  // The last cell's register is the output register. Drop the color for
  // load requests.
  assign m_axis_tvalid = chain[TOTAL].vld;
  assign m_axis_tdata  = (chain[TOTAL].mode == MODE_MAP) ? chain[TOTAL].key : '0;
  assign m_axis_tuser  = chain[TOTAL].status;

endmodule

`default_nettype wire

// ===== sv/pcrt_checker.sv =====
// Port-level checks for the palette color remap table, bound to the top level.
// Depends on pcrt_pkg and palette_color_remap_table_top.
`timescale 1ns / 1ps
`default_nettype none

module pcrt_checker
  import pcrt_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [63:0] s_axis_tdata,
  input wire logic [2:0]  s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic [2:0]  m_axis_tuser
);

  // A held result stays put until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("held result changed");

  // Requests are taken exactly when the output side can move.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output stall");

  // Load results carry no color.
  a_load_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == ST_STORED || m_axis_tuser == ST_DUPLICATE ||
                      m_axis_tuser == ST_FULL) |-> m_axis_tdata == '0)
    else $error("load result with nonzero color");

  // Reset empties the chain.
  a_reset_empty: assert property (@(posedge clk)
    !rst && $past(rst) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

  // An accepted request carries known fields.
  a_req_known: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |-> !$isunknown({s_axis_tuser, s_axis_tdata}))
    else $error("accepted request with unknown fields");

endmodule

bind palette_color_remap_table_top pcrt_checker u_pcrt_checker (.*);

`default_nettype wire
